### rtl/adsg_pkg.sv
// shared types and constants of the domino shuffling grid
`default_nettype none
package adsg_pkg;

  localparam int GRID_DIM  = 128;
  localparam int ROW_W     = 7;
  localparam int SIDE_W    = 8;
  localparam int MAX_ORDER = 64;
  localparam int PROB_BITS = 16;

  localparam int SIDE_CAP = (2 * MAX_ORDER > GRID_DIM) ? GRID_DIM : 2 * MAX_ORDER;
  localparam logic [SIDE_W-1:0] SIDE_GROW_MAX = SIDE_W'(SIDE_CAP - 2);

  localparam logic [16:0] PROB_MASK = 17'(((64'd1 << PROB_BITS) << 1) - 64'd1);
  localparam logic [15:0] RAND_MASK = 16'((64'd1 << PROB_BITS) - 64'd1);

  typedef enum logic [1:0] {
    K_START  = 2'd0,
    K_GROW   = 2'd1,
    K_CREATE = 2'd2,
    K_READ   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    P_NONE = 2'd0,
    P_MAIN = 2'd1,
    P_ANTI = 2'd2
  } placed_t;

  typedef struct packed {
    kind_t            kind;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
    logic             coin_main;
  } cmd_t;

endpackage
`default_nettype wire

### rtl/adsg_ram.sv
// generic single write port ram with registered read
`default_nettype none
module adsg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/adsg_front.sv
// front end: accepts input words, decides the coin and queues commands
`default_nettype none
module adsg_front import adsg_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output      logic             in_ready,
  input  wire logic [1:0]       kind,
  input  wire logic [ROW_W-1:0] row,
  input  wire logic [ROW_W-1:0] col,
  input  wire logic [16:0]      prob,
  input  wire logic [15:0]      rand_val,
  output      logic             q_valid,
  input  wire logic             q_ready,
  output      cmd_t             q_cmd
);

  cmd_t       qmem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  logic       pop;
  cmd_t       dec;

  always_comb begin
    dec.kind      = kind_t'(kind);
    dec.row       = row;
    dec.col       = col;
    dec.coin_main = {1'b0, rand_val & RAND_MASK} < (prob & PROB_MASK);
  end

  assign in_ready = (cnt != 2'd2);
  assign q_valid  = (cnt != 2'd0);
  assign q_cmd    = qmem[rp];
  assign push     = in_valid && in_ready;
  assign pop      = q_ready && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wp] <= dec;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

### rtl/adsg_back.sv
// back end: row sequencer over the grid memory and the result register
`default_nettype none
module adsg_back import adsg_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  output      logic              q_ready,
  input  wire cmd_t              q_cmd,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      logic              cell_value,
  output      logic [1:0]        placed,
  output      logic [SIDE_W-1:0] grid_size,
  output      logic              error
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RADDR = 7'b0000010,
    S_RCAP  = 7'b0000100,
    S_EXEC  = 7'b0001000,
    S_WR0   = 7'b0010000,
    S_WR1   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t              state;
  cmd_t                cmd;
  logic [SIDE_W-1:0]   side;
  logic [ROW_W-1:0]    cur_row;
  logic [1:0]          rd_idx;
  logic [1:0]          rd_last;
  logic [GRID_DIM-1:0] rbuf [4];
  logic [GRID_DIM-1:0] wd0;
  logic [GRID_DIM-1:0] wd1;
  logic [GRID_DIM-1:0] vld;
  logic [ROW_W-1:0]    raddr_q;
  logic                rok_q;
  logic                res_cell;
  placed_t             res_placed;
  logic                res_err;

  logic [8:0]          addr9;
  logic                we;
  logic [ROW_W-1:0]    waddr;
  logic [GRID_DIM-1:0] wdata;
  logic [GRID_DIM-1:0] rdata;
  logic [SIDE_W-1:0]   c8;
  logic [ROW_W-1:0]    half;
  logic                occupied;
  logic [2*GRID_DIM-1:0] grown;

  function automatic logic bit_at(input logic [GRID_DIM-1:0] v, input logic [7:0] idx);
    bit_at = idx[7] ? 1'b0 : v[idx[6:0]];
  endfunction

  // pad by one cell, delete colliding pairs, slide; returns {bottom, top}
  function automatic logic [2*GRID_DIM-1:0] grow_rows(input logic [GRID_DIM-1:0] top_old,
                                                      input logic [GRID_DIM-1:0] bot_old);
    logic [GRID_DIM-1:0] t;
    logic [GRID_DIM-1:0] b;
    logic a, ab, ac, ad;
    t = top_old << 1;
    b = bot_old << 1;
    for (int k = 0; k < GRID_DIM / 2; k++) begin
      a  = t[2*k];
      ab = t[2*k+1];
      ac = b[2*k];
      ad = b[2*k+1];
      if (a && ad) begin
        a  = 1'b0;
        ad = 1'b0;
      end else if (ab && ac) begin
        ab = 1'b0;
        ac = 1'b0;
      end
      if (ad) begin
        a  = 1'b1;
        ad = 1'b0;
      end else if (a) begin
        a  = 1'b0;
        ad = 1'b1;
      end else if (ac) begin
        ab = 1'b1;
        ac = 1'b0;
      end else if (ab) begin
        ac = 1'b1;
        ab = 1'b0;
      end
      t[2*k]   = a;
      t[2*k+1] = ab;
      b[2*k]   = ac;
      b[2*k+1] = ad;
    end
    grow_rows = {b, t};
  endfunction

  adsg_ram #(.WIDTH(GRID_DIM), .DEPTH(GRID_DIM)) u_grid (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (addr9[ROW_W-1:0]),
    .rdata (rdata)
  );

  assign q_ready = (state == S_IDLE);
  assign half    = side[SIDE_W-1:1];
  assign c8      = {cmd.col, 1'b0};

  always_comb begin
    if (cmd.kind == K_READ) begin
      addr9 = {2'b00, cmd.row};
    end else begin
      // row pairs start one above the block: padding shifts rows down by one
      addr9 = {1'b0, cur_row, 1'b0} + {7'd0, rd_idx} - 9'd1;
    end
  end

  assign we    = (state == S_WR0) || (state == S_WR1);
  assign waddr = (state == S_WR1) ? {cur_row[ROW_W-2:0], 1'b1} : {cur_row[ROW_W-2:0], 1'b0};
  assign wdata = (state == S_WR1) ? wd1 : wd0;

  // neighbourhood of the block; cells off the grid read as zero
  assign occupied = rbuf[1][c8[6:0]] | rbuf[1][c8[6:0] + 7'd1]
                  | rbuf[2][c8[6:0]] | rbuf[2][c8[6:0] + 7'd1]
                  | bit_at(rbuf[1], c8 - 8'd1) | bit_at(rbuf[2], c8 - 8'd1)
                  | bit_at(rbuf[1], c8 + 8'd2) | bit_at(rbuf[2], c8 + 8'd2)
                  | rbuf[0][c8[6:0]] | rbuf[0][c8[6:0] + 7'd1]
                  | rbuf[3][c8[6:0]] | rbuf[3][c8[6:0] + 7'd1];

  assign grown = grow_rows(rbuf[0], rbuf[1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      side       <= '0;
      vld        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      if (we) vld[waddr] <= 1'b1;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cmd        <= q_cmd;
            res_cell   <= 1'b0;
            res_placed <= P_NONE;
            res_err    <= 1'b0;
            rd_idx     <= 2'd0;
            unique case (q_cmd.kind)
              K_START: begin
                vld        <= '0;
                side       <= SIDE_W'(2);
                cur_row    <= '0;
                wd0        <= q_cmd.coin_main ? GRID_DIM'(1) : GRID_DIM'(2);
                wd1        <= q_cmd.coin_main ? GRID_DIM'(2) : GRID_DIM'(1);
                res_placed <= q_cmd.coin_main ? P_MAIN : P_ANTI;
                state      <= S_WR0;
              end
              K_GROW: begin
                if (side > SIDE_GROW_MAX) begin
                  res_err <= 1'b1;
                  state   <= S_DONE;
                end else begin
                  cur_row <= half;
                  rd_last <= 2'd1;
                  state   <= S_RADDR;
                end
              end
              K_CREATE: begin
                if (q_cmd.row >= half || q_cmd.col >= half) begin
                  res_err <= 1'b1;
                  state   <= S_DONE;
                end else begin
                  cur_row <= q_cmd.row;
                  rd_last <= 2'd3;
                  state   <= S_RADDR;
                end
              end
              K_READ: begin
                if ({1'b0, q_cmd.row} >= side || {1'b0, q_cmd.col} >= side) begin
                  res_err <= 1'b1;
                  state   <= S_DONE;
                end else begin
                  rd_last <= 2'd0;
                  state   <= S_RADDR;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_RADDR: begin
          raddr_q <= addr9[ROW_W-1:0];
          rok_q   <= (addr9[8:7] == 2'b00);
          state   <= S_RCAP;
        end
        S_RCAP: begin
          rbuf[rd_idx] <= (rok_q && vld[raddr_q]) ? rdata : '0;
          if (rd_idx == rd_last) begin
            state <= S_EXEC;
          end else begin
            rd_idx <= rd_idx + 2'd1;
            state  <= S_RADDR;
          end
        end
        S_EXEC: begin
          unique case (cmd.kind)
            K_READ: begin
              res_cell <= rbuf[0][cmd.col];
              state    <= S_DONE;
            end
            K_CREATE: begin
              if (occupied) begin
                state <= S_DONE;
              end else begin
                if (cmd.coin_main) begin
                  wd0 <= rbuf[1] | (GRID_DIM'(1) << c8[6:0]);
                  wd1 <= rbuf[2] | (GRID_DIM'(2) << c8[6:0]);
                  res_placed <= P_MAIN;
                end else begin
                  wd0 <= rbuf[1] | (GRID_DIM'(2) << c8[6:0]);
                  wd1 <= rbuf[2] | (GRID_DIM'(1) << c8[6:0]);
                  res_placed <= P_ANTI;
                end
                state <= S_WR0;
              end
            end
            K_GROW: begin
              wd0   <= grown[GRID_DIM-1:0];
              wd1   <= grown[2*GRID_DIM-1:GRID_DIM];
              state <= S_WR0;
            end
            default: state <= S_DONE;
          endcase
        end
        S_WR0: state <= S_WR1;
        S_WR1: begin
          // grow walks block rows bottom up so old rows are read before overwrite
          if (cmd.kind == K_GROW && cur_row != '0) begin
            cur_row <= cur_row - ROW_W'(1);
            rd_idx  <= 2'd0;
            state   <= S_RADDR;
          end else begin
            if (cmd.kind == K_GROW) side <= side + SIDE_W'(2);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            cell_value <= res_cell;
            placed     <= res_placed;
            grid_size  <= side;
            error      <= res_err;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/aztec_domino_shuffling_grid_core.sv
// throughput: one word at a time in the back end; grid memory port sets the row rate
// grow walks block rows bottom up, two row reads and two row writes per block row
// reset clears a valid bit per grid row at once, so the grid reads as zero with no sweep
// a two word command queue lets the input side keep accepting while the back end works
`default_nettype none
module aztec_domino_shuffling_grid_core import adsg_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire logic [1:0]        kind,
  input  wire logic [ROW_W-1:0]  row,
  input  wire logic [ROW_W-1:0]  col,
  input  wire logic [16:0]       prob,
  input  wire logic [15:0]       rand_val,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      logic              cell_value,
  output      logic [1:0]        placed,
  output      logic [SIDE_W-1:0] grid_size,
  output      logic              error
);

  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  adsg_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .row      (row),
    .col      (col),
    .prob     (prob),
    .rand_val (rand_val),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd)
  );

  adsg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_cmd      (q_cmd),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cell_value (cell_value),
    .placed     (placed),
    .grid_size  (grid_size),
    .error      (error)
  );

  a_size_even: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (grid_size[0] == 1'b0))
    else $error("grid size odd");

  a_err_no_place: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error) |-> (placed == P_NONE && cell_value == 1'b0))
    else $error("error word carries a result");

  a_place_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (placed != 2'd3 && !(placed != P_NONE && cell_value)))
    else $error("bad placed code");

endmodule
`default_nettype wire

### sim/tb_checker.sv
// checker: watches both channels, predicts the grid block and compares results
`default_nettype none
module tb_checker import adsg_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire logic [1:0]        kind,
  input  wire logic [ROW_W-1:0]  row,
  input  wire logic [ROW_W-1:0]  col,
  input  wire logic [16:0]       prob,
  input  wire logic [15:0]       rand_val,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire logic              cell_value,
  input  wire logic [1:0]        placed,
  input  wire logic [SIDE_W-1:0] grid_size,
  input  wire logic              error,
  output int                     fail_count,
  output int                     pending
);

  typedef struct packed {
    logic              bit_val;
    placed_t           plc;
    logic [SIDE_W-1:0] size;
    logic              err;
  } grid_result_t;

  logic        model_grid [GRID_DIM][GRID_DIM];
  logic        pad_grid   [GRID_DIM+2][GRID_DIM+2];
  int          model_side;
  grid_result_t expected_q [$];

  function automatic logic coin_toss(logic [16:0] p, logic [15:0] r);
    return {1'b0, r & RAND_MASK} < (p & PROB_MASK);
  endfunction

  function automatic logic cell_at(int r, int c);
    if (r < 0 || c < 0 || r >= GRID_DIM || c >= GRID_DIM) return 1'b0;
    return model_grid[r][c];
  endfunction

  task automatic place_pair(int r, int c, logic on_main);
    if (on_main) begin
      model_grid[r][c] = 1'b1;
      model_grid[r+1][c+1] = 1'b1;
    end else begin
      model_grid[r+1][c] = 1'b1;
      model_grid[r][c+1] = 1'b1;
    end
  endtask

  task automatic shuffle_grow();
    int n;
    int half;
    int r;
    int c;
    n = model_side;
    half = n / 2;
    foreach (pad_grid[i, j]) pad_grid[i][j] = 1'b0;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) pad_grid[i+1][j+1] = model_grid[i][j];
    // annihilate colliding pairs
    for (int i = 0; i < half; i++)
      for (int j = 0; j < half; j++) begin
        r = 2 * i;
        c = 2 * j;
        if (pad_grid[r][c] && pad_grid[r+1][c+1]) begin
          pad_grid[r][c] = 1'b0;
          pad_grid[r+1][c+1] = 1'b0;
        end else if (pad_grid[r][c+1] && pad_grid[r+1][c]) begin
          pad_grid[r][c+1] = 1'b0;
          pad_grid[r+1][c] = 1'b0;
        end
      end
    // slide survivors across their block
    for (int i = 0; i <= half; i++)
      for (int j = 0; j <= half; j++) begin
        r = 2 * i;
        c = 2 * j;
        if (pad_grid[r+1][c+1]) begin
          pad_grid[r][c] = 1'b1;
          pad_grid[r+1][c+1] = 1'b0;
        end else if (pad_grid[r][c]) begin
          pad_grid[r][c] = 1'b0;
          pad_grid[r+1][c+1] = 1'b1;
        end else if (pad_grid[r+1][c]) begin
          pad_grid[r][c+1] = 1'b1;
          pad_grid[r+1][c] = 1'b0;
        end else if (pad_grid[r][c+1]) begin
          pad_grid[r+1][c] = 1'b1;
          pad_grid[r][c+1] = 1'b0;
        end
      end
    for (int i = 0; i < GRID_DIM; i++)
      for (int j = 0; j < GRID_DIM; j++) model_grid[i][j] = pad_grid[i][j];
    model_side = n + 2;
  endtask

  function automatic logic block_free(int bi, int bj, int half);
    int r;
    int c;
    r = 2 * bi;
    c = 2 * bj;
    if (cell_at(r, c) || cell_at(r+1, c) || cell_at(r, c+1) || cell_at(r+1, c+1)) return 0;
    if (bj > 0 && (cell_at(r, c-1) || cell_at(r+1, c-1))) return 0;
    if (bj + 1 < half && (cell_at(r, c+2) || cell_at(r+1, c+2))) return 0;
    if (bi > 0 && (cell_at(r-1, c) || cell_at(r-1, c+1))) return 0;
    if (bi + 1 < half && (cell_at(r+2, c) || cell_at(r+2, c+1))) return 0;
    return 1;
  endfunction

  task automatic predict_word();
    grid_result_t res;
    logic m;
    int half;
    res = '0;
    res.plc = P_NONE;
    case (kind_t'(kind))
      K_START: begin
        m = coin_toss(prob, rand_val);
        foreach (model_grid[i, j]) model_grid[i][j] = 1'b0;
        model_side = 2;
        place_pair(0, 0, m);
        res.plc = m ? P_MAIN : P_ANTI;
      end
      K_GROW: begin
        if (model_side + 2 > SIDE_CAP) res.err = 1'b1;
        else shuffle_grow();
      end
      K_CREATE: begin
        half = model_side / 2;
        if (row >= half || col >= half) res.err = 1'b1;
        else if (block_free(row, col, half)) begin
          m = coin_toss(prob, rand_val);
          place_pair(2 * row, 2 * col, m);
          res.plc = m ? P_MAIN : P_ANTI;
        end
      end
      default: begin
        if (row >= model_side || col >= model_side) res.err = 1'b1;
        else res.bit_val = model_grid[row][col];
      end
    endcase
    res.size = SIDE_W'(model_side);
    expected_q.insert(expected_q.size(), res);
  endtask

  always @(posedge clk) begin
    grid_result_t exp_res;
    if (rst) begin
      foreach (model_grid[i, j]) model_grid[i][j] = 1'b0;
      model_side = 0;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (in_valid && in_ready) predict_word();
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          exp_res = expected_q.pop_front();
          if (cell_value !== exp_res.bit_val) begin
            $error("cell_value: expected %0d, got %0d", exp_res.bit_val, cell_value);
            fail_count++;
          end
          if (placed !== exp_res.plc) begin
            $error("placed: expected %0d, got %0d", exp_res.plc, placed);
            fail_count++;
          end
          if (grid_size !== exp_res.size) begin
            $error("grid_size: expected %0d, got %0d", exp_res.size, grid_size);
            fail_count++;
          end
          if (error !== exp_res.err) begin
            $error("error: expected %0d, got %0d", exp_res.err, error);
            fail_count++;
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule
`default_nettype wire

### sim/tb_top.sv
// top of the grid testbench: stimulus, handshake idling and verdict
`default_nettype none
module tb_top import adsg_pkg::*;;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        kind = '0;
  logic [ROW_W-1:0]  row = '0;
  logic [ROW_W-1:0]  col = '0;
  logic [16:0]       prob = '0;
  logic [15:0]       rand_val = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              cell_value;
  logic [1:0]        placed;
  logic [SIDE_W-1:0] grid_size;
  logic              error;
  int                fail_count;
  int                pending;
  int                idle_cycles = 0;
  int                word_count = 0;
  int                grow_count = 0;
  int                stall_mode = 0;

  localparam int IDLE_LIMIT = 20000;

  always #1 clk = ~clk;

  aztec_domino_shuffling_grid_core dut (.*);

  tb_checker chk (.*);

  // receiver back-pressure with its own changing pattern
  always @(posedge clk) begin
    if (($urandom % 300) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom % 4) != 0;
      2:       out_ready <= ($urandom % 3) == 0;
      default: out_ready <= ($urandom % 16) < 15;
    endcase
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("[aztec_domino_shuffling_grid_core] ERROR");
      $finish;
    end
  end

  task automatic send_word(kind_t k, int r, int c, int p, int rv);
    in_valid <= 1'b1;
    kind     <= k;
    row      <= ROW_W'(r);
    col      <= ROW_W'(c);
    prob     <= 17'(p);
    rand_val <= 16'(rv);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    word_count++;
    if (k == K_GROW) grow_count++;
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // mostly well-placed words, coordinates kept near the live grid
  task automatic random_word(int side);
    int pick;
    int half;
    pick = $urandom_range(0, 99);
    half = (side < 2) ? 1 : side / 2;
    if (pick < 3)
      send_word(K_START, $urandom, $urandom, $urandom_range(0, 65536), $urandom);
    else if (pick < 13)
      send_word(K_GROW, $urandom, $urandom, $urandom, $urandom);
    else if (pick < 55)
      send_word(K_CREATE, ($urandom % 10) ? $urandom_range(0, half - 1) : $urandom,
                ($urandom % 10) ? $urandom_range(0, half - 1) : $urandom,
                $urandom_range(0, 65536), $urandom);
    else
      send_word(K_READ, ($urandom % 10) ? $urandom_range(0, side + 1) : $urandom,
                ($urandom % 10) ? $urandom_range(0, side + 1) : $urandom,
                $urandom, $urandom);
  endtask

  initial begin
    int side;
    int burst;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: work before start, coin extremes, growth limits, border reads
    send_word(K_CREATE, 0, 0, 65536, 0);
    send_word(K_READ, 0, 0, 0, 0);
    send_word(K_GROW, 0, 0, 0, 0);
    send_word(K_READ, 1, 1, 0, 0);
    send_word(K_START, 127, 127, 65536, 65535);
    send_word(K_READ, 0, 0, 0, 0);
    send_word(K_START, 0, 0, 0, 0);
    send_word(K_READ, 0, 1, 131071, 65535);
    send_word(K_START, 0, 0, 100, 99);
    send_word(K_START, 0, 0, 100, 100);
    send_word(K_GROW, 0, 0, 0, 0);
    send_word(K_CREATE, 0, 0, 131071, 0);
    send_word(K_CREATE, 1, 1, 0, 65535);
    send_word(K_CREATE, 2, 0, 1, 0);
    send_word(K_READ, 3, 3, 0, 0);
    send_word(K_READ, 4, 0, 0, 0);
    send_word(K_READ, 127, 127, 0, 0);
    idle_gap(1);
    for (int g = 0; g < 64; g++) send_word(K_GROW, 0, 0, 0, 0);
    send_word(K_READ, 127, 127, 0, 0);
    send_word(K_CREATE, 63, 63, 65536, 0);
    send_word(K_READ, 0, 127, 0, 0);
    send_word(K_START, 0, 0, 32768, 40000);

    // hold off until every result is back
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);

    side = 2;
    while (word_count < 780) begin
      burst = ($urandom % 4 == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      repeat (burst) begin
        // keep most grids small so grow walks stay short
        if (side >= 24 && ($urandom % 3) != 0) begin
          send_word(K_START, 0, 0, $urandom_range(0, 65536), $urandom);
          side = 2;
        end else begin
          random_word(side);
          if (kind == K_GROW && side < SIDE_CAP) side += 2;
          else if (kind == K_START) side = 2;
        end
      end
      idle_gap(($urandom % 3 == 0) ? 0 : $urandom_range(1, 12));
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    $display("covered %0d words (%0d grow), starts, creates and reads in and out of range",
             word_count, grow_count);
    if (fail_count == 0 && pending == 0) begin
      $display("[aztec_domino_shuffling_grid_core] OK");
    end else begin
      $display("[aztec_domino_shuffling_grid_core] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
